// ----- rtl/tmh_pkg.sv -----
// ---------------------------------------------------------------------------
// tmh_pkg: shared types, constants and helpers for the track mode fsm
// Q1.15 levels (1.0 = 32768), saturating 16-bit frame counters, code values.
// ---------------------------------------------------------------------------
`default_nettype none

package tmh_pkg;

   // fixed design constants
   localparam logic [15:0] DWELL_FLOOR_FRAMES = 16'd5;
   localparam logic [15:0] EXIT_RUN_FRAMES    = 16'd3;
   localparam logic        RESET_MODE         = 1'b0;

   localparam logic [15:0] ONE_Q15 = 16'd32768;
   localparam logic [15:0] CNT_MAX = 16'hFFFF;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;

   // two-state tracking mode
   typedef enum logic {
      MODE_AMBIGUOUS  = 1'b0,
      MODE_STRUCTURED = 1'b1
   } mode_type;

   // switch reason codes
   typedef enum logic [1:0] {
      REASON_NONE      = 2'd0,
      REASON_ENTER     = 2'd1,
      REASON_REBIND    = 2'd2,
      REASON_WEAK_EXIT = 2'd3
   } reason_type;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTER_SCORE_THR = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXIT_SCORE_THR  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTROPY_HIGH    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTROPY_LOW     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROB_LOW        = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROB_HIGH       = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_FRAMES   = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTER_CONFIRM   = 4'd7;

   // configuration reset values
   localparam logic [15:0] RST_ENTER_SCORE_THR = 16'd19661;
   localparam logic [15:0] RST_EXIT_SCORE_THR  = 16'd19661;
   localparam logic [15:0] RST_ENTROPY_HIGH    = 16'd22938;
   localparam logic [15:0] RST_ENTROPY_LOW     = 16'd16384;
   localparam logic [15:0] RST_PROB_LOW        = 16'd16384;
   localparam logic [15:0] RST_PROB_HIGH       = 16'd22938;
   localparam logic [7:0]  RST_STABLE_FRAMES   = 8'd3;
   localparam logic [7:0]  RST_ENTER_CONFIRM   = 8'd3;

   function automatic logic [15:0] sat_inc(input logic [15:0] c);
      return (c == CNT_MAX) ? CNT_MAX : c + 16'd1;
   endfunction

   function automatic logic [15:0] cap_one(input logic [15:0] v);
      return (v > ONE_Q15) ? ONE_Q15 : v;
   endfunction

   function automatic logic [7:0] at_least_one8(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   function automatic logic [15:0] at_least_one16(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   localparam logic [15:0] DWELL_REQ     = at_least_one16(DWELL_FLOOR_FRAMES);
   localparam logic [15:0] EXIT_CONF_REQ = at_least_one16(EXIT_RUN_FRAMES);

endpackage

`default_nettype wire

// ----- rtl/track_mode_hysteresis_fsm_core.sv -----
// path: input reg, then result reg, which loads once it is empty or its response is taken
// throughput: one request per cycle, sustained while the response side takes results
// the mode and counter state updates when a request moves from the input reg to the
// result reg, so each request sees the state left by the one before it
// reset: synchronous active high; mode to RESET_MODE, counters and candidate cleared,
// configuration registers to their default levels, both stages empty
// ---------------------------------------------------------------------------
// track_mode_hysteresis_fsm_core: ambiguous / structured mode hysteresis
// Takes one frame of tracking evidence per request and returns the mode, a
// switched flag, the switch reason and a clamped Q1.15 confidence.
// ---------------------------------------------------------------------------
`default_nettype none

module track_mode_hysteresis_fsm_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration write port
   input  wire logic                                csr_we,
   input  wire logic [tmh_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [tmh_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [15:0]                         req_enter_score,
   input  wire logic [15:0]                         req_exit_score,
   input  wire logic [15:0]                         req_entropy_level,
   input  wire logic [15:0]                         req_peak_prob,
   input  wire logic                                req_candidate_valid,
   input  wire logic [15:0]                         req_candidate_id,
   input  wire logic                                req_jump_event,
   input  wire logic                                req_signature_seen,
   input  wire logic                                req_force_rebind,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_track_mode,
   output logic                                     rsp_switched,
   output logic [1:0]                               rsp_reason,
   output logic [15:0]                              rsp_confidence
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [15:0] enter_thr_ff, exit_thr_ff;
   logic [15:0] ent_high_ff, ent_low_ff, prob_low_ff, prob_high_ff;
   logic [7:0]  stable_need_ff, confirm_need_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enter_thr_ff    <= tmh_pkg::RST_ENTER_SCORE_THR;
         exit_thr_ff     <= tmh_pkg::RST_EXIT_SCORE_THR;
         ent_high_ff     <= tmh_pkg::RST_ENTROPY_HIGH;
         ent_low_ff      <= tmh_pkg::RST_ENTROPY_LOW;
         prob_low_ff     <= tmh_pkg::RST_PROB_LOW;
         prob_high_ff    <= tmh_pkg::RST_PROB_HIGH;
         stable_need_ff  <= tmh_pkg::RST_STABLE_FRAMES;
         confirm_need_ff <= tmh_pkg::RST_ENTER_CONFIRM;
      end else if (csr_we) begin
         case (csr_index)
            tmh_pkg::CSR_ENTER_SCORE_THR: enter_thr_ff    <= csr_wdata;
            tmh_pkg::CSR_EXIT_SCORE_THR:  exit_thr_ff     <= csr_wdata;
            tmh_pkg::CSR_ENTROPY_HIGH:    ent_high_ff     <= csr_wdata;
            tmh_pkg::CSR_ENTROPY_LOW:     ent_low_ff      <= csr_wdata;
            tmh_pkg::CSR_PROB_LOW:        prob_low_ff     <= csr_wdata;
            tmh_pkg::CSR_PROB_HIGH:       prob_high_ff    <= csr_wdata;
            tmh_pkg::CSR_STABLE_FRAMES:   stable_need_ff  <= csr_wdata[7:0];
            tmh_pkg::CSR_ENTER_CONFIRM:   confirm_need_ff <= csr_wdata[7:0];
            default: ; // index beyond the list: write dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipeline handshake
   // ------------------------------------------------------------------
   logic in_valid_ff;
   logic out_valid_ff;
   logic advance;       // input reg moves into result reg, state commits

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   // input reg refills in the same cycle it drains
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // input register (payload, no reset)
   // ------------------------------------------------------------------
   logic [15:0] enter_score_ff, exit_score_ff, entropy_ff, peak_ff, cand_id_ff;
   logic        cand_valid_ff, jump_ff, sig_ff, rebind_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         enter_score_ff <= req_enter_score;
         exit_score_ff  <= req_exit_score;
         entropy_ff     <= req_entropy_level;
         peak_ff        <= req_peak_prob;
         cand_valid_ff  <= req_candidate_valid;
         cand_id_ff     <= req_candidate_id;
         jump_ff        <= req_jump_event;
         sig_ff         <= req_signature_seen;
         rebind_ff      <= req_force_rebind;
      end
   end

   // ------------------------------------------------------------------
   // mode state and frame counters
   // ------------------------------------------------------------------
   tmh_pkg::mode_type mode_ff, mode_in;
   logic [15:0] enter_cnt_ff, enter_cnt_in;
   logic [15:0] exit_cnt_ff, exit_cnt_in;
   logic [15:0] stable_cnt_ff, stable_cnt_in;
   logic [15:0] dwell_cnt_ff, dwell_cnt_in;
   logic        last_valid_ff, last_valid_in;
   logic [15:0] last_id_ff, last_id_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= tmh_pkg::mode_type'(tmh_pkg::RESET_MODE);
         enter_cnt_ff  <= '0;
         exit_cnt_ff   <= '0;
         stable_cnt_ff <= '0;
         dwell_cnt_ff  <= '0;
         last_valid_ff <= 1'b0;
         last_id_ff    <= '0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         enter_cnt_ff  <= enter_cnt_in;
         exit_cnt_ff   <= exit_cnt_in;
         stable_cnt_ff <= stable_cnt_in;
         dwell_cnt_ff  <= dwell_cnt_in;
         last_valid_ff <= last_valid_in;
         last_id_ff    <= last_id_in;
      end
   end

   // ------------------------------------------------------------------
   // next state and frame result
   // ------------------------------------------------------------------
   logic [15:0]         conf_in;
   logic                switched_in;
   tmh_pkg::reason_type reason_in;

   logic [15:0] exit_conf;
   logic [15:0] stable_req;     // zero-extended, at least one
   logic [15:0] confirm_req;
   logic [15:0] st_req;         // larger of confirm and stable needs
   logic        post_enter, post_exit, enter_hit;
   logic        go_enter, go_exit;
   logic [15:0] peak_or_enter;

   always_comb begin
      exit_conf   = tmh_pkg::ONE_Q15 - tmh_pkg::cap_one(exit_score_ff);
      stable_req  = {8'd0, tmh_pkg::at_least_one8(stable_need_ff)};
      confirm_req = {8'd0, tmh_pkg::at_least_one8(confirm_need_ff)};
      st_req      = (confirm_req > stable_req) ? confirm_req : stable_req;

      post_enter = (entropy_ff < tmh_pkg::cap_one(ent_low_ff)) &&
                   (peak_ff > tmh_pkg::cap_one(prob_high_ff));
      post_exit  = (entropy_ff > tmh_pkg::cap_one(ent_high_ff)) ||
                   (peak_ff < tmh_pkg::cap_one(prob_low_ff));
      enter_hit  = enter_score_ff >= enter_thr_ff;

      peak_or_enter = (enter_score_ff > peak_ff) ? enter_score_ff : peak_ff;

      mode_in      = mode_ff;
      enter_cnt_in = enter_cnt_ff;
      exit_cnt_in  = exit_cnt_ff;
      dwell_cnt_in = tmh_pkg::sat_inc(dwell_cnt_ff);
      go_enter     = 1'b0;
      go_exit      = 1'b0;
      reason_in    = tmh_pkg::REASON_NONE;

      // candidate stability tracking
      if (cand_valid_ff) begin
         if (last_valid_ff && (last_id_ff == cand_id_ff)) begin
            stable_cnt_in = tmh_pkg::sat_inc(stable_cnt_ff);
            last_valid_in = last_valid_ff;
            last_id_in    = last_id_ff;
         end else begin
            stable_cnt_in = 16'd1;
            last_valid_in = 1'b1;
            last_id_in    = cand_id_ff;
         end
      end else begin
         stable_cnt_in = '0;
         last_valid_in = 1'b0;
         last_id_in    = '0;
      end

      case (mode_ff)
         tmh_pkg::MODE_AMBIGUOUS: begin
            // event with strong score, or a stable posterior, enters at once
            if (((jump_ff || sig_ff) && enter_hit) ||
                (post_enter && (stable_cnt_in >= stable_req))) begin
               go_enter = 1'b1;
            end else if (enter_hit) begin
               enter_cnt_in = tmh_pkg::sat_inc(enter_cnt_ff);
               if ((enter_cnt_in >= confirm_req) && (stable_cnt_in >= st_req)) begin
                  go_enter = 1'b1;
               end
            end else begin
               enter_cnt_in = '0;
            end
         end
         tmh_pkg::MODE_STRUCTURED: begin
            if (rebind_ff) begin
               go_exit   = 1'b1;
               reason_in = tmh_pkg::REASON_REBIND;
            end else if (dwell_cnt_in >= tmh_pkg::DWELL_REQ) begin
               // weak exit only counts once the minimum dwell has passed
               if (post_exit || (exit_score_ff >= exit_thr_ff)) begin
                  exit_cnt_in = tmh_pkg::sat_inc(exit_cnt_ff);
                  if (exit_cnt_in >= tmh_pkg::EXIT_CONF_REQ) begin
                     go_exit   = 1'b1;
                     reason_in = tmh_pkg::REASON_WEAK_EXIT;
                  end
               end else begin
                  exit_cnt_in = '0;
               end
            end
         end
         default: ;
      endcase

      // confidence in the mode held before this frame
      conf_in = (mode_ff == tmh_pkg::MODE_STRUCTURED) ?
                tmh_pkg::cap_one(enter_score_ff) : exit_conf;

      if (go_enter) begin
         mode_in   = tmh_pkg::MODE_STRUCTURED;
         reason_in = tmh_pkg::REASON_ENTER;
         conf_in   = tmh_pkg::cap_one(peak_or_enter);
      end else if (go_exit) begin
         mode_in = tmh_pkg::MODE_AMBIGUOUS;
         conf_in = exit_conf;
      end

      switched_in = go_enter || go_exit;
      if (switched_in) begin
         enter_cnt_in = '0;
         exit_cnt_in  = '0;
         dwell_cnt_in = '0;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   logic                mode_out_ff;
   logic                switched_ff;
   tmh_pkg::reason_type reason_ff;
   logic [15:0]         conf_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_out_ff <= mode_in;
         switched_ff <= switched_in;
         reason_ff   <= reason_in;
         conf_ff     <= conf_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_track_mode = mode_out_ff;
   assign rsp_switched   = switched_ff;
   assign rsp_reason     = reason_ff;
   assign rsp_confidence = conf_ff;

endmodule

`default_nettype wire

// ----- rtl/tmh_checker.sv -----
// ---------------------------------------------------------------------------
// tmh_checker: port-level assertions for the track mode fsm
// Watches the response channel for consistency of mode, reason and confidence.
// ---------------------------------------------------------------------------
`default_nettype none

module tmh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_track_mode,
   input wire logic        rsp_switched,
   input wire logic [1:0]  rsp_reason,
   input wire logic [15:0] rsp_confidence
);

   // a reason is given exactly on switching frames
   a_reason_iff_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_switched == (rsp_reason != tmh_pkg::REASON_NONE)))
      else $error("reason and switched flag disagree");

   // the reason matches the mode that was entered
   a_reason_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_switched) |->
         (rsp_track_mode == (rsp_reason == tmh_pkg::REASON_ENTER)))
      else $error("switch reason does not match new mode");

   // confidence is clamped to one
   a_conf_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_confidence <= tmh_pkg::ONE_Q15))
      else $error("confidence above one");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_track_mode) && $stable(rsp_switched) &&
          $stable(rsp_reason) && $stable(rsp_confidence)))
      else $error("stalled response changed");

endmodule

bind track_mode_hysteresis_fsm_core tmh_checker u_tmh_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_track_mode (rsp_track_mode),
   .rsp_switched   (rsp_switched),
   .rsp_reason     (rsp_reason),
   .rsp_confidence (rsp_confidence)
);

`default_nettype wire
